// ===== rtl/r2y420_pkg.sv =====
// Package for the RGB to YCbCr 4:2:0 subsampler.
// Holds beat types, fixed conversion constants and field widths; no dependencies.
package r2y420_pkg;

	localparam int CFG_W = 12;
	localparam int ROW_W = 11;
	localparam int SUM_W = 9;
	localparam int POS_W = 10;
	localparam int IMAGE_WIDTH_RESET = 640;
	localparam int MIN_WIDTH = 2;
	localparam int CHROMA_OFFSET = 128;

	// coefficients in units of 1/10000, rounded to nearest on conversion
	localparam longint Q_DEN = 10000;
	localparam longint Q_HALF = 5000;
	localparam longint K_Y_R = 2990;
	localparam longint K_Y_G = 5870;
	localparam longint K_Y_B = 1140;
	localparam longint K_CB_R = 1687;
	localparam longint K_CB_G = 3312;
	localparam longint K_CB_B = 5000;
	localparam longint K_CR_R = 5000;
	localparam longint K_CR_G = 4186;
	localparam longint K_CR_B = 813;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pixel_t;

	typedef struct packed {
		logic [7:0]       luma;
		logic             chroma_valid;
		logic [7:0]       cb_average;
		logic [7:0]       cr_average;
		logic [POS_W-1:0] chroma_x;
		logic [POS_W-1:0] chroma_y;
	} result_t;

endpackage

// ===== rtl/r2y420_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module r2y420_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/r2y420_csc.sv =====
// Two-stage colour space converter: products, then sums with truncation and saturation.
// Depends on r2y420_pkg for the coefficient constants.
module r2y420_csc #(
	parameter int FRAC_BITS = 14
) (
	input  logic       clk,
	input  logic       en1,
	input  logic       en2,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] luma_s2,
	output logic [7:0] cb_s2,
	output logic [7:0] cr_s2
);

	localparam int CW = FRAC_BITS;
	localparam int PW = FRAC_BITS + 8;
	localparam int AW = FRAC_BITS + 10;

	localparam logic [CW-1:0] C_YR =
		CW'(((r2y420_pkg::K_Y_R << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_YG =
		CW'(((r2y420_pkg::K_Y_G << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_YB =
		CW'(((r2y420_pkg::K_Y_B << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_BR =
		CW'(((r2y420_pkg::K_CB_R << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_BG =
		CW'(((r2y420_pkg::K_CB_G << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_BB =
		CW'(((r2y420_pkg::K_CB_B << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_RR =
		CW'(((r2y420_pkg::K_CR_R << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_RG =
		CW'(((r2y420_pkg::K_CR_G << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [CW-1:0] C_RB =
		CW'(((r2y420_pkg::K_CR_B << FRAC_BITS) + r2y420_pkg::Q_HALF) / r2y420_pkg::Q_DEN);
	localparam logic [AW-1:0] OFS = AW'(longint'(r2y420_pkg::CHROMA_OFFSET) << FRAC_BITS);

	logic [PW-1:0] p_yr_s1, p_yg_s1, p_yb_s1;
	logic [PW-1:0] p_br_s1, p_bg_s1, p_bb_s1;
	logic [PW-1:0] p_rr_s1, p_rg_s1, p_rb_s1;
	logic [AW-1:0] acc_y, acc_cb, acc_cr;

	function automatic logic [7:0] sat8(input logic [AW-1:0] a);
		logic [7:0] v;
		if (a[AW-1]) begin
			v = 8'd0;
		end else if (|a[AW-2:FRAC_BITS+8]) begin
			v = 8'hFF;
		end else begin
			v = a[FRAC_BITS+7:FRAC_BITS];
		end
		return v;
	endfunction

	always_ff @(posedge clk) begin
		if (en1) begin
			p_yr_s1 <= PW'(red) * PW'(C_YR);
			p_yg_s1 <= PW'(green) * PW'(C_YG);
			p_yb_s1 <= PW'(blue) * PW'(C_YB);
			p_br_s1 <= PW'(red) * PW'(C_BR);
			p_bg_s1 <= PW'(green) * PW'(C_BG);
			p_bb_s1 <= PW'(blue) * PW'(C_BB);
			p_rr_s1 <= PW'(red) * PW'(C_RR);
			p_rg_s1 <= PW'(green) * PW'(C_RG);
			p_rb_s1 <= PW'(blue) * PW'(C_RB);
		end
	end

	always_comb begin
		acc_y  = AW'(p_yr_s1) + AW'(p_yg_s1) + AW'(p_yb_s1);
		acc_cb = OFS + AW'(p_bb_s1) - AW'(p_br_s1) - AW'(p_bg_s1);
		acc_cr = OFS + AW'(p_rr_s1) - AW'(p_rg_s1) - AW'(p_rb_s1);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			luma_s2 <= sat8(acc_y);
			cb_s2   <= sat8(acc_cb);
			cr_s2   <= sat8(acc_cr);
		end
	end

endmodule

// ===== rtl/rgb_to_ycbcr_420_subsampler.sv =====
// RGB to YCbCr 4:2:0 subsampler top level: position counters, line store, pair sums.
// Depends on r2y420_pkg, r2y420_csc and r2y420_ram.
//
// Pixels arrive in raster order on the pixel channel (valid/ready); frame_start
// on a beat restarts column and row at zero. Each pixel gives one result beat
// carrying its luma; on odd rows at odd columns the beat also carries the
// floored 2x2 mean of Cb and Cr and the chroma position.
// cfg_data sets the row width; write it only while the block is idle.
// A result passes through the product, sum and output registers, the first
// loaded at the edge that accepts its pixel.
// Throughput: one pixel per cycle while results are taken, held by the line store
// taking one read per pixel and one write per pixel pair of an even row, with a
// bypass when a write and a read of the same entry meet.
// Reset: width 640, counters and pair sums cleared, pipeline empty. The line
// store is not cleared; every entry is written on an even row before it is read.
// Stalls: a stalled result holds in the output register while the two earlier
// stages keep filling; pixel_ready drops once all three stages are occupied.
module rgb_to_ycbcr_420_subsampler #(
	parameter int MAX_WIDTH = 2048,
	parameter int COEFF_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  r2y420_pkg::pixel_t                  pixel,
	output logic                                result_valid,
	input  logic                                result_ready,
	output r2y420_pkg::result_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [r2y420_pkg::CFG_W-1:0]        cfg_data
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW_W = ($clog2(MAX_WIDTH + 1) > r2y420_pkg::CFG_W) ?
		$clog2(MAX_WIDTH + 1) : r2y420_pkg::CFG_W;
	localparam int ROW_W = r2y420_pkg::ROW_W;
	localparam int SUM_W = r2y420_pkg::SUM_W;
	localparam int POS_W = r2y420_pkg::POS_W;
	localparam int LINE_W = 2 * SUM_W;
	localparam logic [EW_W-1:0] MAXW = EW_W'(MAX_WIDTH);
	localparam logic [EW_W-1:0] MINW = EW_W'(r2y420_pkg::MIN_WIDTH);
	localparam logic [EW_W-1:0] EW_RST = (r2y420_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
		MAXW : EW_W'(r2y420_pkg::IMAGE_WIDTH_RESET);

	logic [EW_W-1:0]   width_q, width_d;
	logic [COL_W-1:0]  col_q, col_d, cur_col;
	logic [ROW_W-1:0]  row_q, row_d, cur_row;
	logic [EW_W:0]     col_inc;

	logic              en1, en2, en_o, acc;
	logic              v1_q, v2_q;

	logic              odd_col_s1, odd_row_s1, fwd_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [POS_W-1:0]  cx_s1, cy_s1;
	logic [LINE_W-1:0] fwd_data_s1;

	logic              odd_col_s2, odd_row_s2;
	logic [ADDR_W-1:0] idx_s2;
	logic [POS_W-1:0]  cx_s2, cy_s2;
	logic [LINE_W-1:0] line_s2;
	logic [7:0]        luma_s2, cb_s2, cr_s2;

	logic [SUM_W-1:0]  pair_cb_q, pair_cr_q, cb_sum, cr_sum;
	logic [SUM_W:0]    cb_tot, cr_tot;

	logic              wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [LINE_W-1:0] wr_data, rd_data;

	r2y420_pkg::result_t res, result_q;
	logic              ov_q;

	// handshakes and pipeline advance
	assign en_o = !ov_q || result_ready;
	assign en2 = !v2_q || en_o;
	assign en1 = !v1_q || en2;
	assign pixel_ready = en1;
	assign acc = pixel_valid && en1;
	assign cfg_ready = 1'b1;
	assign result_valid = ov_q;
	assign result = result_q;

	// effective width, taken at write time
	always_comb begin
		width_d = EW_W'({cfg_data[r2y420_pkg::CFG_W-1:1], 1'b0});
		if (width_d < MINW) begin
			width_d = MINW;
		end else if (width_d > MAXW) begin
			width_d = MAXW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= EW_RST;
		end else if (cfg_valid) begin
			width_q <= width_d;
		end
	end

	// raster position
	always_comb begin
		cur_col = pixel.frame_start ? '0 : col_q;
		cur_row = pixel.frame_start ? '0 : row_q;
		col_inc = (EW_W + 1)'(cur_col) + (EW_W + 1)'(1);
		if (col_inc >= {1'b0, width_q}) begin
			col_d = '0;
			row_d = cur_row + ROW_W'(1);
		end else begin
			col_d = COL_W'(col_inc);
			row_d = cur_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	assign rd_addr = ADDR_W'(cur_col >> 1);

	// line store: {cb pair sum, cr pair sum} of the even row
	r2y420_ram #(
		.WIDTH(LINE_W),
		.DEPTH(DEPTH)
	) u_line (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(idx_s2),
		.wr_data(wr_data),
		.rd_en  (acc),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	r2y420_csc #(
		.FRAC_BITS(COEFF_FRAC_BITS)
	) u_csc (
		.clk    (clk),
		.en1    (acc),
		.en2    (en2 && v1_q),
		.red    (pixel.red),
		.green  (pixel.green),
		.blue   (pixel.blue),
		.luma_s2(luma_s2),
		.cb_s2  (cb_s2),
		.cr_s2  (cr_s2)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= pixel_valid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
			if (en_o) begin
				ov_q <= v2_q;
			end
		end
	end

	// stage 1: position and bypass of a write landing on the same entry
	always_ff @(posedge clk) begin
		if (acc) begin
			odd_col_s1  <= cur_col[0];
			odd_row_s1  <= cur_row[0];
			idx_s1      <= rd_addr;
			cx_s1       <= POS_W'(cur_col >> 1);
			cy_s1       <= cur_row[POS_W:1];
			fwd_s1      <= wr_en && (idx_s2 == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	// stage 2
	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			odd_col_s2 <= odd_col_s1;
			odd_row_s2 <= odd_row_s1;
			idx_s2     <= idx_s1;
			cx_s2      <= cx_s1;
			cy_s2      <= cy_s1;
			line_s2    <= fwd_s1 ? fwd_data_s1 : rd_data;
		end
	end

	// pair sums, line store write and result
	always_comb begin
		cb_sum  = SUM_W'(pair_cb_q + SUM_W'(cb_s2));
		cr_sum  = SUM_W'(pair_cr_q + SUM_W'(cr_s2));
		wr_data = {cb_sum, cr_sum};
		wr_en   = v2_q && en_o && odd_col_s2 && !odd_row_s2;
		cb_tot  = (SUM_W + 1)'(line_s2[LINE_W-1:SUM_W]) + (SUM_W + 1)'(cb_sum);
		cr_tot  = (SUM_W + 1)'(line_s2[SUM_W-1:0]) + (SUM_W + 1)'(cr_sum);

		res = '0;
		res.luma = luma_s2;
		if (odd_col_s2 && odd_row_s2) begin
			res.chroma_valid = 1'b1;
			res.cb_average   = cb_tot[SUM_W:2];
			res.cr_average   = cr_tot[SUM_W:2];
			res.chroma_x     = cx_s2;
			res.chroma_y     = cy_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_cb_q <= '0;
			pair_cr_q <= '0;
		end else if (v2_q && en_o) begin
			pair_cb_q <= odd_col_s2 ? cb_sum : SUM_W'(cb_s2);
			pair_cr_q <= odd_col_s2 ? cr_sum : SUM_W'(cr_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v2_q) begin
			result_q <= res;
		end
	end

endmodule

// ===== rtl/r2y420_checker.sv =====
// Port-level checks for the RGB to YCbCr 4:2:0 subsampler, bound to the top level.
// Depends on r2y420_pkg and rgb_to_ycbcr_420_subsampler.
module r2y420_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                pixel_valid,
	input logic                pixel_ready,
	input r2y420_pkg::pixel_t  pixel,
	input logic                result_valid,
	input logic                result_ready,
	input r2y420_pkg::result_t result
);

	logic [2:0] inflight_q;
	logic       in_beat, out_beat;

	assign in_beat = pixel_valid && pixel_ready;
	assign out_beat = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != 3'd0)
		else $error("result beat without a pending pixel");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more than three pixels in flight");

	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.chroma_valid |->
			result.cb_average == 8'd0 && result.cr_average == 8'd0 &&
			result.chroma_x == '0 && result.chroma_y == '0)
		else $error("chroma fields set on a luma-only beat");

endmodule

bind rgb_to_ycbcr_420_subsampler r2y420_checker u_r2y420_checker (.*);
